/* sv/gftr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gftr_pkg
// Shared constants and helpers for the GOP frame type and reference block.
// ----------------------------------------------------------------------------
package gftr_pkg;

    localparam int FNUM_BITS_DEF = 32;
    localparam int CFG_BITS      = 16;
    localparam int CFG_IDX_BITS  = 8;
    localparam int REF_BITS      = 32;
    localparam int EXP_BITS      = 31;
    localparam int OUT_BITS      = 104;

    localparam logic [CFG_IDX_BITS-1:0] REG_GOP_LENGTH = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_L1_SPACING = 8'd1;

    localparam logic [1:0] CLS_INTRA = 2'd0;
    localparam logic [1:0] CLS_L1    = 2'd1;
    localparam logic [1:0] CLS_L2    = 2'd2;

    localparam logic [EXP_BITS-1:0] EXPIRY_NEVER = 31'h4000_0000;

    // one restoring division step: shift in a bit, subtract if it fits
    function automatic logic [CFG_BITS-1:0] div_step(
        input logic [CFG_BITS-1:0] rem,
        input logic                din,
        input logic [CFG_BITS-1:0] dvs
    );
        logic [CFG_BITS:0] t;
        t = {rem, din};
        if (t >= {1'b0, dvs}) begin
            t = t - {1'b0, dvs};
        end
        return t[CFG_BITS-1:0];
    endfunction

endpackage

/* sv/gop_frame_type_and_refs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gop_frame_type_and_refs
// Classifies a display-order frame number and gives its references and expiry.
// ----------------------------------------------------------------------------
// channel  | dir | fields (low bit up)
// s_axis   | in  | frame_number[31:0]
// m_axis   | out | class[1:0] count[3:2] ref1[35:4] ref2[67:36] expiry[98:68]
// cfg      | in  | index 0 gop_length, 1 level1_spacing
//
// One beat per cycle while m_axis does not stall. Three remainder
// units retire one dividend bit per stage, then one output stage.
// Reset clears valid bits and sets gop_length 0, level1_spacing 1.
// A stall at m_axis holds the whole pipe; s_axis_tready follows it.
// ----------------------------------------------------------------------------
module gop_frame_type_and_refs
    import gftr_pkg::*;
#(
    parameter int FRAME_NUM_BITS = FNUM_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [31:0]             s_axis_tdata,   // frame_number
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_BITS-1:0]     m_axis_tdata    // class, count, ref1, ref2, expiry
);

    localparam int W = FRAME_NUM_BITS;

    logic [CFG_BITS-1:0] r_gop;
    logic [CFG_BITS-1:0] r_spc;

    logic                en;
    logic                r_v  [W];
    logic [W-1:0]        r_n  [W];
    logic [W-1:0]        r_p  [W];
    logic [CFG_BITS-1:0] r_ra [W];
    logic [CFG_BITS-1:0] r_rb [W];
    logic [CFG_BITS-1:0] r_rc [W];

    logic [1:0]          r_cls, n_cls;
    logic [1:0]          r_cnt, n_cnt;
    logic [W-1:0]        r_r1, n_r1;
    logic [W-1:0]        r_r2, n_r2;
    logic [EXP_BITS-1:0] r_exp, n_exp;
    logic                r_ov;

    assign en            = !r_ov || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gop <= '0;
            r_spc <= CFG_BITS'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_GOP_LENGTH) begin
                r_gop <= i_cfg_data;
            end else if (i_cfg_idx == REG_L1_SPACING) begin
                r_spc <= (i_cfg_data == '0) ? CFG_BITS'(1) : i_cfg_data;
            end
        end
    end

    // stage k retires dividend bit W-1-k of n (mod G, mod S) and prev (mod G)
    for (genvar k = 0; k < W; k++) begin : g_div
        logic                nv;
        logic [W-1:0]        nn, np;
        logic [CFG_BITS-1:0] na, nb, nc;
        if (k == 0) begin : g_head
            assign nv = s_axis_tvalid;
            assign nn = s_axis_tdata[W-1:0];
            assign np = s_axis_tdata[W-1:0] - W'(r_spc);
            assign na = '0;
            assign nb = '0;
            assign nc = '0;
        end else begin : g_body
            assign nv = r_v[k-1];
            assign nn = r_n[k-1];
            assign np = r_p[k-1];
            assign na = r_ra[k-1];
            assign nb = r_rb[k-1];
            assign nc = r_rc[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en) begin
                r_v[k] <= nv;
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_n[k]  <= nn;
                r_p[k]  <= np;
                r_ra[k] <= div_step(na, nn[W-1-k], r_gop);
                r_rb[k] <= div_step(nb, nn[W-1-k], r_spc);
                r_rc[k] <= div_step(nc, np[W-1-k], r_gop);
            end
        end
    end

    always_comb begin
        logic [W-1:0]        n, p, sw;
        logic [CFG_BITS-1:0] ra, rb, rc;
        n     = r_n[W-1];
        p     = r_p[W-1];
        ra    = r_ra[W-1];
        rb    = r_rb[W-1];
        rc    = r_rc[W-1];
        sw    = W'(r_spc);
        n_cls = CLS_INTRA;
        n_cnt = 2'd0;
        n_r1  = '0;
        n_r2  = '0;
        n_exp = EXP_BITS'(r_gop);
        if (r_gop != '0 && ra == '0) begin
            n_exp = EXP_BITS'(r_gop);
        end else if (r_gop == '0 && n == '0) begin
            n_exp = EXPIRY_NEVER;
        end else if (rb == '0) begin
            n_cls = CLS_L1;
            n_exp = EXP_BITS'(r_spc);
            n_cnt = 2'd1;
            if (r_gop != '0) begin
                n_r1 = n - W'(ra);
                if (rc != '0) begin
                    n_r2  = p;
                    n_cnt = 2'd2;
                end
            end else if (n != sw) begin
                n_r2  = p;
                n_cnt = 2'd2;
            end
        end else begin
            n_cls = CLS_L2;
            n_cnt = 2'd2;
            n_r1  = n - W'(rb);
            n_r2  = n - W'(rb) + sw;
            n_exp = EXP_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_v[W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cls <= n_cls;
            r_cnt <= n_cnt;
            r_r1  <= n_r1;
            r_r2  <= n_r2;
            r_exp <= n_exp;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {5'd0, r_exp, REF_BITS'(r_r2), REF_BITS'(r_r1), r_cnt, r_cls};

    a_spc_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spc != '0) else $error("level-1 spacing held at zero");
    a_intra_norefs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_cls == CLS_INTRA |-> r_cnt == 2'd0 && r_r1 == '0 && r_r2 == '0)
        else $error("intra frame with references");
    a_l2_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_cls == CLS_L2 |-> r_cnt == 2'd2 && r_exp == EXP_BITS'(1))
        else $error("level-2 frame malformed");
    a_l1_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_cls == CLS_L1 |-> r_cnt != 2'd0 && r_exp == EXP_BITS'(r_spc))
        else $error("level-1 frame malformed");

endmodule
